[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on the rising clock edge, disabled while reset is low.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assert that a condition implies a consequence in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Assert that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/cbsfe_pkg.sv]
// Shared types, line codes and check helpers of the frame encoder.
// No dependencies; used by front, queue, back, top level and checker.
package cbsfe_pkg;

	// Line codes
	localparam logic [7:0] FLAG_BYTE = 8'h7e;
	localparam logic [7:0] ESC_BYTE  = 8'h7d;
	localparam logic [7:0] ESC_FLAG  = 8'h5e;
	localparam logic [7:0] ESC_ESC   = 8'h5d;

	// Check constants
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_TOP  = 16'h8000;

	// Check mode codes
	localparam logic MODE_CRC = 1'b0;
	localparam logic MODE_SUM = 1'b1;

	// Default depth of the queue between front and back (at least 2)
	localparam int QUEUE_DEPTH = 4;

	// One classified body byte handed from front to back
	typedef struct packed {
		logic        open;      // emit the opening flag first
		logic [7:0]  body;      // unescaped body byte
		logic        last;      // final body byte, check and close follow
		logic        mode;      // check mode sampled at the final byte
		logic [31:0] check_val; // CRC in the low half, or the raw word sum
	} entry_t;

	// Queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// Bitwise CRC-16 over one byte, message bits MSB first
	function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		logic        top;
		r = c;
		for (int i = 7; i >= 0; i--) begin
			top = r[15];
			r = {r[14:0], 1'b0};
			if (top) r = r ^ CRC_POLY;
			if (b[i]) r = r ^ CRC_POLY;
		end
		return r;
	endfunction

	// True for bytes that need an escape on the line
	function automatic logic is_special(input logic [7:0] b);
		return (b == FLAG_BYTE) || (b == ESC_BYTE);
	endfunction

	// Second byte of an escape pair
	function automatic logic [7:0] esc_code(input logic [7:0] b);
		return (b == FLAG_BYTE) ? ESC_FLAG : ESC_ESC;
	endfunction

endpackage

[rtl/core/crc_byte_stuffing_frame_encoder.sv]
// Frame encoder top level: byte-stuffed frames with a trailing 16-bit check.
// Depends on cbsfe_pkg, cbsfe_front, cbsfe_queue and cbsfe_back.
//
// Each accepted body byte yields its wire bytes on the output channel: an
// opening 0x7e before the first byte of a frame, the byte itself with 0x7e
// and 0x7d sent as 0x7d 0x5e and 0x7d 0x5d, and after the byte marked
// frame_last the 16-bit check (high byte first, escaped alike) and a closing
// 0x7e flagged by frame_end. run_last marks the final wire byte of each body
// byte. check_mode (0 = CRC-16 0x1021 seed 0, 1 = ones'-complement word sum)
// is sampled at the final body byte; the user must write it only while idle,
// which the block itself does not enforce. The front takes one body byte per
// cycle while the queue (QUEUE_DEPTH entries) has room; the back sends one
// wire byte per cycle unless out_stall holds it. An accepted byte passes
// through a queue slot and the back's beat register before its first wire
// byte reaches the output register.
module crc_byte_stuffing_frame_encoder #(
	parameter int QUEUE_DEPTH = cbsfe_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write,
	input  logic       cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] body_byte,
	input  logic       frame_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] line_byte,
	output logic       run_last,
	output logic       frame_end
);

	cbsfe_pkg::q_status_t q_status;
	cbsfe_pkg::entry_t    push_entry;
	cbsfe_pkg::entry_t    head_entry;
	logic                 push;
	logic                 pop;

	cbsfe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.body_byte  (body_byte),
		.frame_last (frame_last),
		.q_status   (q_status),
		.push       (push),
		.push_entry (push_entry)
	);

	cbsfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head_entry (head_entry),
		.q_status   (q_status)
	);

	cbsfe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_entry (head_entry),
		.q_status   (q_status),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.line_byte  (line_byte),
		.run_last   (run_last),
		.frame_end  (frame_end)
	);

endmodule

[rtl/core/cbsfe_front.sv]
// Front of the frame encoder: accepts body bytes, runs both checks, classifies.
// Depends on cbsfe_pkg; feeds cbsfe_queue.
module cbsfe_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  logic                cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          body_byte,
	input  logic                frame_last,
	input  cbsfe_pkg::q_status_t q_status,
	output logic                push,
	output cbsfe_pkg::entry_t   push_entry
);

	logic        mode_q;
	logic [15:0] crc_q;
	logic [31:0] sum_q;
	logic        pending_q;
	logic [7:0]  held_q;
	logic        inside_q;

	logic [15:0] crc_next;
	logic [15:0] addend;
	logic [31:0] sum_next;

	// Stall while the queue has no room
	assign in_stall = q_status.full;
	assign push     = in_valid && !in_stall;

	// Advance both checks by this byte; one adder serves words and the odd tail
	always_comb begin
		crc_next = cbsfe_pkg::crc_byte(crc_q, body_byte);
		if (pending_q) begin
			addend = {held_q, body_byte};
		end else if (frame_last) begin
			addend = {8'h00, body_byte};
		end else begin
			addend = 16'h0000;
		end
		sum_next = sum_q + {16'h0000, addend};
	end

	// Classify the beat for the back
	always_comb begin
		push_entry.open      = !inside_q;
		push_entry.body      = body_byte;
		push_entry.last      = frame_last;
		push_entry.mode      = mode_q;
		push_entry.check_val = (mode_q == cbsfe_pkg::MODE_SUM) ? sum_next
			: {16'h0000, crc_next};
	end

	// Hold the check mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= cbsfe_pkg::MODE_CRC;
		end else if (cfg_write) begin
			mode_q <= cfg_data;
		end
	end

	// Update running check state; drop it all at frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q     <= '0;
			sum_q     <= '0;
			pending_q <= 1'b0;
			held_q    <= '0;
			inside_q  <= 1'b0;
		end else if (push) begin
			if (frame_last) begin
				crc_q     <= '0;
				sum_q     <= '0;
				pending_q <= 1'b0;
				held_q    <= '0;
				inside_q  <= 1'b0;
			end else begin
				crc_q     <= crc_next;
				sum_q     <= sum_next;
				pending_q <= !pending_q;
				if (!pending_q) begin
					held_q <= body_byte;
				end
				inside_q  <= 1'b1;
			end
		end
	end

endmodule

[rtl/core/cbsfe_queue.sv]
// Short queue of classified body bytes between front and back.
// Depends on cbsfe_pkg for the entry and status types.
module cbsfe_queue #(
	parameter int DEPTH = cbsfe_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  cbsfe_pkg::entry_t    push_entry,
	input  logic                 pop,
	output cbsfe_pkg::entry_t    head_entry,
	output cbsfe_pkg::q_status_t q_status
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	cbsfe_pkg::entry_t slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign head_entry     = slot_q[rd_ptr_q];
	assign q_status.full  = (count_q == FULL_CNT);
	assign q_status.empty = (count_q == '0);

	// Store pushed beats
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/cbsfe_back.sv]
// Back of the frame encoder: expands queued beats into escaped line bytes.
// Depends on cbsfe_pkg; drains cbsfe_queue into the output register.
module cbsfe_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cbsfe_pkg::entry_t    head_entry,
	input  cbsfe_pkg::q_status_t q_status,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           line_byte,
	output logic                 run_last,
	output logic                 frame_end
);

	typedef enum logic [7:0] {
		ST_OPEN     = 8'b0000_0001,
		ST_BODY     = 8'b0000_0010,
		ST_BODY_ESC = 8'b0000_0100,
		ST_HI       = 8'b0000_1000,
		ST_HI_ESC   = 8'b0001_0000,
		ST_LO       = 8'b0010_0000,
		ST_LO_ESC   = 8'b0100_0000,
		ST_CLOSE    = 8'b1000_0000
	} step_t;

	step_t             step_q;
	step_t             step_d;
	logic              busy_q;
	cbsfe_pkg::entry_t entry_q;
	logic [16:0]       fold1_q;
	logic [15:0]       chk_q;

	logic              out_valid_q;
	logic [7:0]        line_byte_q;
	logic              run_last_q;
	logic              frame_end_q;

	logic [7:0]        emit_byte;
	logic              emit_last;
	logic              emit_end;
	logic              done;
	logic              advance;

	assign out_valid = out_valid_q;
	assign line_byte = line_byte_q;
	assign run_last  = run_last_q;
	assign frame_end = frame_end_q;

	// Advance when the output register is free or being taken
	assign advance = busy_q && (!out_valid_q || !out_stall);
	assign pop     = !q_status.empty && (!busy_q || (advance && done));

	// Pick the byte of the current step and the step after it
	always_comb begin
		emit_byte = entry_q.body;
		emit_last = 1'b0;
		emit_end  = 1'b0;
		done      = 1'b0;
		step_d    = step_q;
		case (step_q)
			ST_OPEN: begin
				emit_byte = cbsfe_pkg::FLAG_BYTE;
				step_d    = ST_BODY;
			end
			ST_BODY: begin
				if (cbsfe_pkg::is_special(entry_q.body)) begin
					emit_byte = cbsfe_pkg::ESC_BYTE;
					step_d    = ST_BODY_ESC;
				end else if (entry_q.last) begin
					step_d = ST_HI;
				end else begin
					emit_last = 1'b1;
					done      = 1'b1;
				end
			end
			ST_BODY_ESC: begin
				emit_byte = cbsfe_pkg::esc_code(entry_q.body);
				if (entry_q.last) begin
					step_d = ST_HI;
				end else begin
					emit_last = 1'b1;
					done      = 1'b1;
				end
			end
			ST_HI: begin
				if (cbsfe_pkg::is_special(chk_q[15:8])) begin
					emit_byte = cbsfe_pkg::ESC_BYTE;
					step_d    = ST_HI_ESC;
				end else begin
					emit_byte = chk_q[15:8];
					step_d    = ST_LO;
				end
			end
			ST_HI_ESC: begin
				emit_byte = cbsfe_pkg::esc_code(chk_q[15:8]);
				step_d    = ST_LO;
			end
			ST_LO: begin
				if (cbsfe_pkg::is_special(chk_q[7:0])) begin
					emit_byte = cbsfe_pkg::ESC_BYTE;
					step_d    = ST_LO_ESC;
				end else begin
					emit_byte = chk_q[7:0];
					step_d    = ST_CLOSE;
				end
			end
			ST_LO_ESC: begin
				emit_byte = cbsfe_pkg::esc_code(chk_q[7:0]);
				step_d    = ST_CLOSE;
			end
			ST_CLOSE: begin
				emit_byte = cbsfe_pkg::FLAG_BYTE;
				emit_last = 1'b1;
				emit_end  = 1'b1;
				done      = 1'b1;
			end
			default: begin
				done = 1'b1;
			end
		endcase
	end

	// Load a new beat or step through the current one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= ST_OPEN;
		end else if (pop) begin
			busy_q <= 1'b1;
			step_q <= head_entry.open ? ST_OPEN : ST_BODY;
		end else if (advance) begin
			if (done) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= step_d;
			end
		end
	end

	// Hold the beat; fold the word sum once at load, finish it in the next cycle
	always_ff @(posedge clk) begin
		if (pop) begin
			entry_q <= head_entry;
			fold1_q <= {1'b0, head_entry.check_val[31:16]}
				+ {1'b0, head_entry.check_val[15:0]};
		end
		chk_q <= (entry_q.mode == cbsfe_pkg::MODE_SUM)
			? ~(fold1_q[15:0] + {15'h0000, fold1_q[16]})
			: entry_q.check_val[15:0];
	end

	// Output register: fill on advance, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			line_byte_q <= emit_byte;
			run_last_q  <= emit_last;
			frame_end_q <= emit_end;
		end
	end

endmodule

[rtl/core/cbsfe_checker.sv]
// Port-level checks of the frame encoder, bound to the top level.
// Depends on cbsfe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cbsfe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] line_byte,
	input logic       run_last,
	input logic       frame_end
);

	// A stalled output beat holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(line_byte) && $stable(run_last) && $stable(frame_end), "stalled output beat changed")

	// The closing flag is a flag and ends its run
	`ASSERT_IMPL(a_close_flag, clk, arst_n, out_valid && frame_end, line_byte == cbsfe_pkg::FLAG_BYTE && run_last, "closing flag malformed")

	// An escape byte never ends a run
	`ASSERT_IMPL(a_esc_not_last, clk, arst_n, out_valid && line_byte == cbsfe_pkg::ESC_BYTE, !run_last && !frame_end, "escape byte ends a run")

	// An opening flag never ends a run
	`ASSERT_IMPL(a_open_not_last, clk, arst_n, out_valid && line_byte == cbsfe_pkg::FLAG_BYTE && !frame_end, !run_last, "opening flag ends a run")

endmodule

bind crc_byte_stuffing_frame_encoder cbsfe_checker u_cbsfe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.line_byte (line_byte),
	.run_last  (run_last),
	.frame_end (frame_end)
);

[verif/cbsfe_line_checker.sv]
// Line-side checker for the frame encoder: predicts wire bytes from body beats
// and compares them against the output channel. Depends on cbsfe_pkg.
module cbsfe_line_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write,
	input  logic       cfg_data,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] body_byte,
	input  logic       frame_last,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] line_byte,
	input  logic       run_last,
	input  logic       frame_end,
	output int         fail_count,
	output int         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [7:0] line;
		logic       run_last;
		logic       frame_end;
	} wire_beat_t;

	// Expected wire bytes, oldest first
	wire_beat_t wire_q[$];

	// Shadow of the encoder state
	logic [15:0] crc_acc;
	logic [31:0] sum_acc;
	logic        odd_pend;
	logic [7:0]  held_hi;
	logic        in_frame;
	logic        mode_sel;
	int          beat_no;

	initial begin
		fail_count = 0;
		pending = 0;
	end

	task automatic report_mismatch(input string what, input logic [7:0] got,
		input logic [7:0] want);
		if (fail_count < 40)
			$display("mismatch at wire beat %0d: %s got %02h want %02h",
				beat_no, what, got, want);
		fail_count++;
	endtask

	function automatic logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c;
		// Shift out MSB first; feedback and message bit each add the poly once
		for (int i = 7; i >= 0; i--)
			r = {r[14:0], 1'b0} ^ ((r[15] ^ b[i]) ? cbsfe_pkg::CRC_POLY : 16'h0000);
		return r;
	endfunction

	task automatic add_wire(input logic [7:0] b, input logic fe);
		wire_beat_t w;
		w.line = b;
		w.run_last = 1'b0;
		w.frame_end = fe;
		wire_q.insert(wire_q.size(), w);
	endtask

	task automatic add_stuffed(input logic [7:0] b);
		if (b == cbsfe_pkg::FLAG_BYTE) begin
			add_wire(cbsfe_pkg::ESC_BYTE, 1'b0);
			add_wire(cbsfe_pkg::ESC_FLAG, 1'b0);
		end else if (b == cbsfe_pkg::ESC_BYTE) begin
			add_wire(cbsfe_pkg::ESC_BYTE, 1'b0);
			add_wire(cbsfe_pkg::ESC_ESC, 1'b0);
		end else begin
			add_wire(b, 1'b0);
		end
	endtask

	// Predict every wire byte caused by one body byte
	task automatic encode_body_byte(input logic [7:0] b, input logic last);
		logic [31:0] s;
		logic [15:0] chk;
		if (!in_frame) begin
			add_wire(cbsfe_pkg::FLAG_BYTE, 1'b0);
			in_frame = 1'b1;
		end
		add_stuffed(b);
		crc_acc = crc_update(crc_acc, b);
		if (odd_pend) begin
			sum_acc = sum_acc + {16'h0000, held_hi, b};
			odd_pend = 1'b0;
		end else begin
			held_hi = b;
			odd_pend = 1'b1;
		end
		if (last) begin
			if (mode_sel == cbsfe_pkg::MODE_CRC) begin
				chk = crc_acc;
			end else begin
				s = sum_acc;
				if (odd_pend)
					s = s + {24'h0, held_hi};
				s = {16'h0000, s[31:16]} + {16'h0000, s[15:0]};
				s = s + {16'h0000, s[31:16]};
				chk = ~s[15:0];
			end
			add_stuffed(chk[15:8]);
			add_stuffed(chk[7:0]);
			add_wire(cbsfe_pkg::FLAG_BYTE, 1'b1);
			crc_acc = '0;
			sum_acc = '0;
			odd_pend = 1'b0;
			held_hi = '0;
			in_frame = 1'b0;
		end
		wire_q[wire_q.size() - 1].run_last = 1'b1;
	endtask

	// Track config, predict on input beats, compare on output beats
	always @(posedge clk or negedge arst_n) begin
		wire_beat_t w;
		if (!arst_n) begin
			crc_acc = '0;
			sum_acc = '0;
			odd_pend = 1'b0;
			held_hi = '0;
			in_frame = 1'b0;
			mode_sel = cbsfe_pkg::MODE_CRC;
			beat_no = 0;
			wire_q.delete();
		end else begin
			if (cfg_write)
				mode_sel = cfg_data;
			if (in_valid && !in_stall)
				encode_body_byte(body_byte, frame_last);
			if (out_valid && !out_stall) begin
				if (wire_q.size() == 0) begin
					report_mismatch("unexpected line_byte", line_byte, 8'h00);
				end else begin
					w = wire_q.pop_front();
					if (line_byte !== w.line)
						report_mismatch("line_byte", line_byte, w.line);
					if (run_last !== w.run_last)
						report_mismatch("run_last", {7'b0, run_last}, {7'b0, w.run_last});
					if (frame_end !== w.frame_end)
						report_mismatch("frame_end", {7'b0, frame_end}, {7'b0, w.frame_end});
				end
				beat_no++;
			end
		end
		pending = wire_q.size();
	end

endmodule

[verif/crc_byte_stuffing_frame_encoder_tb.sv]
// Testbench top for the frame encoder: clock, reset, body-byte stimulus with
// random idling and backpressure. Depends on cbsfe_pkg and cbsfe_line_checker.
module crc_byte_stuffing_frame_encoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic       clk;
	logic       arst_n;
	logic       cfg_write;
	logic       cfg_data;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] body_byte;
	logic       frame_last;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] line_byte;
	logic       run_last;
	logic       frame_end;
	int         fail_count;
	int         pending;

	// Stimulus controls; quiet and rx_hold_req are shared with the receiver process
	bit         quiet;
	bit         rx_hold_req;
	int         bytes_sent;

	crc_byte_stuffing_frame_encoder u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.body_byte  (body_byte),
		.frame_last (frame_last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.line_byte  (line_byte),
		.run_last   (run_last),
		.frame_end  (frame_end)
	);

	cbsfe_line_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.body_byte  (body_byte),
		.frame_last (frame_last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.line_byte  (line_byte),
		.run_last   (run_last),
		.frame_end  (frame_end),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Gap before the next body beat: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 19);
		if (r < 10)
			return 0;
		if (r < 18)
			return $urandom_range(1, 3);
		return $urandom_range(8, 25);
	endfunction

	// Random body byte, biased toward the bytes that need stuffing and their escape codes
	function automatic logic [7:0] pick_body();
		case ($urandom_range(0, 9))
			0: return cbsfe_pkg::FLAG_BYTE;
			1: return cbsfe_pkg::ESC_BYTE;
			2: return ($urandom_range(0, 1) != 0) ? cbsfe_pkg::ESC_FLAG : cbsfe_pkg::ESC_ESC;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Offer one body beat and hold it until accepted
	task automatic send_body(input logic [7:0] b, input logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		body_byte <= b;
		frame_last <= last;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
	endtask

	// Stop offering and wait until every predicted wire byte has been seen
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Write the check mode while the encoder is idle
	task automatic set_mode(input logic m);
		drain();
		cfg_write <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic send_frame(input int len);
		for (int i = 0; i < len; i++)
			send_body(pick_body(), i == len - 1);
	endtask

	// Receiver: random stall bursts, a long hold on request, none when quiet
	initial begin
		int hold_left;
		out_stall <= 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				out_stall <= 1'b1;
				hold_left = 250;
			end else if (hold_left > 0) begin
				hold_left--;
			end else if (quiet) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(0, 9) < 3);
				hold_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
					: $urandom_range(0, 2);
			end
		end
	end

	// Stimulus and verdict
	initial begin
		int frames;
		int flen;
		int split_at;
		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_data <= 1'b0;
		in_valid <= 1'b0;
		body_byte <= '0;
		frame_last <= 1'b0;
		quiet = 1'b0;
		rx_hold_req = 1'b0;
		bytes_sent = 0;
		frames = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single-byte frames at the extremes and the stuffed codes, then one longer frame, CRC mode
		set_mode(cbsfe_pkg::MODE_CRC);
		send_body(8'h00, 1'b1);
		send_body(8'hff, 1'b1);
		send_body(cbsfe_pkg::FLAG_BYTE, 1'b1);
		send_body(cbsfe_pkg::ESC_BYTE, 1'b1);
		send_body(cbsfe_pkg::FLAG_BYTE, 1'b0);
		send_body(cbsfe_pkg::ESC_BYTE, 1'b0);
		send_body(8'h00, 1'b0);
		send_body(8'hff, 1'b0);
		send_body(cbsfe_pkg::ESC_FLAG, 1'b0);
		send_body(cbsfe_pkg::ESC_ESC, 1'b1);

		// Word sum: all-ones words, odd and even lengths, single byte
		set_mode(cbsfe_pkg::MODE_SUM);
		send_body(8'hff, 1'b0);
		send_body(8'hff, 1'b0);
		send_body(8'hff, 1'b0);
		send_body(8'hff, 1'b1);
		send_body(8'h12, 1'b0);
		send_body(8'h34, 1'b0);
		send_body(8'h56, 1'b1);
		send_body(8'hab, 1'b0);
		send_body(8'hcd, 1'b1);
		send_body(cbsfe_pkg::FLAG_BYTE, 1'b1);

		// Switch mode mid-frame; the final byte decides the check
		send_body(8'h01, 1'b0);
		send_body(8'h02, 1'b0);
		set_mode(cbsfe_pkg::MODE_CRC);
		send_body(8'h03, 1'b1);

		// Random frames, with config changes, quiet stretches and a long hold
		while (bytes_sent < 360) begin
			frames++;
			if ($urandom_range(0, 5) == 0)
				set_mode(1'($urandom_range(0, 1)));
			quiet = (frames % 17) >= 14;
			if (frames == 12) begin
				// Receiver holds off while the sender keeps pushing
				quiet = 1'b1;
				rx_hold_req = 1'b1;
				send_frame(30);
				quiet = 1'b0;
			end else if (frames == 25) begin
				// Sender pauses until every wire byte is out
				drain();
				send_frame($urandom_range(1, 6));
			end else begin
				flen = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24)
					: $urandom_range(1, 6);
				split_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, flen) : 0;
				for (int i = 0; i < flen; i++) begin
					if (i == split_at && i > 0)
						set_mode(1'($urandom_range(0, 1)));
					send_body(pick_body(), i == flen - 1);
				end
			end
		end
		quiet = 1'b0;

		// Let the last frame drain, then allow a little slack
		drain();
		repeat (16) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Hard limit on the whole run
	initial begin
		#10_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
